FILE: src/srrw_pkg.sv
// shared constants and types for the selective-repeat receive window
`default_nettype none
package srrw_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

	localparam int SEQ_W  = 8;
	localparam int TAG_W  = 16;
	localparam int WS_W   = 5;
	localparam int CFG_W  = 8;

	// modulo unit: dividend and divisor cover max_seq + 1 = 256
	localparam int MOD_W      = SEQ_W + 1;
	localparam int MOD_STEPS  = 3;
	localparam int MOD_CYCLES = MOD_W / MOD_STEPS;
	localparam int MOD_CNT_W  = $clog2(MOD_CYCLES + 1);

	localparam logic CFG_WINDOW_SIZE = 1'b0;
	localparam logic CFG_MAX_SEQ     = 1'b1;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_NACK    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_number;
		logic             crc_good;
		logic [TAG_W-1:0] frame_tag;
	} frame_t;

	typedef struct packed {
		kind_t            result_kind;
		logic [SEQ_W-1:0] result_number;
		logic [TAG_W-1:0] delivered_tag;
		logic             last_result;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] dividend;
		logic [MOD_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] rem;
	} mod_rsp_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [TAG_W-1:0]  wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} store_req_t;

endpackage
`default_nettype wire

FILE: src/selective_repeat_receive_window_unit.sv
// selective-repeat receive window: sequencer, marks, window edges and result register
// a rejected request frees the input with no result; an accepted one gives its last result
// after the results of its delivered frames, plus stalls; one request at a time, and the
// input is free again in the same cycle that the last result becomes valid; a remainder pass
// runs for the slot, then for slot, next_expected, window_upper
// reset clears marks and next_expected, arms nak, loads window 4, max_seq 7; window_upper = 4
`default_nettype none
module selective_repeat_receive_window_unit
	import srrw_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             frame_valid,
	output logic                  frame_ready,
	input  wire frame_t           frame,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output result_t               result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SLOT, ST_CHECK, ST_DSLOT, ST_ADV1, ST_ADV2, ST_EMIT, ST_FINAL
	} state_t;

	localparam logic [MOD_W-1:0] MAX_WIN_M = MOD_W'(MAX_WINDOW);

	state_t            state_q;
	logic [WS_W-1:0]   window_size_q;
	logic [SEQ_W-1:0]  max_seq_q;
	logic [MAX_WINDOW-1:0] marks_q;
	logic [SEQ_W-1:0]  ne_q;
	logic [SEQ_W-1:0]  wu_q;
	logic              nak_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              good_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SEQ_W-1:0]  ne_nxt_q;
	logic [SLOT_W-1:0] dslot_q;
	logic              result_valid_q;
	result_t           result_q;

	mod_req_t          mod_req;
	mod_rsp_t          mod_rsp;
	store_req_t        st_req;
	logic [TAG_W-1:0]  st_rdata;

	logic [MOD_W-1:0]  w_eff;
	logic [MOD_W-1:0]  modulus;
	logic [SLOT_W-1:0] rem_slot;
	logic              accept_in;
	logic              out_free;
	logic              take_frame;
	logic              more_deliver;

	function automatic logic in_window(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
		input logic [SEQ_W-1:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

	always_comb begin
		w_eff = {{(MOD_W-WS_W){1'b0}}, window_size_q};
		if (window_size_q == '0) begin
			w_eff = MOD_W'(1);
		end else if (w_eff > MAX_WIN_M) begin
			w_eff = MAX_WIN_M;
		end
	end

	assign modulus      = {1'b0, max_seq_q} + MOD_W'(1);
	assign rem_slot     = mod_rsp.rem[SLOT_W-1:0];
	assign frame_ready  = (state_q == ST_IDLE);
	assign accept_in    = frame_valid && frame_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign take_frame   = good_q && !marks_q[rem_slot] && in_window(ne_q, seq_q, wu_q);
	assign more_deliver = marks_q[rem_slot] && (cnt_q < CNT_W'(MAX_WINDOW));

	always_comb begin
		mod_req = '0;
		st_req  = '0;
		st_req.waddr = rem_slot;
		st_req.wdata = tag_q;
		st_req.raddr = rem_slot;
		unique case (state_q)
			ST_IDLE: begin
				mod_req.start    = accept_in;
				mod_req.dividend = {1'b0, frame.seq_number};
				mod_req.divisor  = w_eff;
			end
			ST_SLOT: begin
				st_req.we = mod_rsp.done && take_frame;
			end
			ST_CHECK: begin
				mod_req.start    = 1'b1;
				mod_req.dividend = {1'b0, ne_q};
				mod_req.divisor  = w_eff;
			end
			ST_DSLOT: begin
				mod_req.start    = mod_rsp.done && more_deliver;
				mod_req.dividend = {1'b0, ne_q} + MOD_W'(1);
				mod_req.divisor  = modulus;
				st_req.re        = mod_rsp.done && more_deliver;
			end
			ST_ADV1: begin
				mod_req.start    = mod_rsp.done;
				mod_req.dividend = {1'b0, wu_q} + MOD_W'(1);
				mod_req.divisor  = modulus;
			end
			ST_ADV2, ST_EMIT, ST_FINAL: begin
			end
			default: begin
			end
		endcase
	end

	srrw_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	srrw_store u_store (
		.clk   (clk),
		.req   (st_req),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_size_q  <= WS_W'(4);
			max_seq_q      <= SEQ_W'(7);
			marks_q        <= '0;
			ne_q           <= '0;
			wu_q           <= SEQ_W'(4);
			nak_q          <= 1'b1;
			cnt_q          <= '0;
			ne_nxt_q       <= '0;
			dslot_q        <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW_SIZE: window_size_q <= cfg_data[WS_W-1:0];
					CFG_MAX_SEQ:     max_seq_q     <= cfg_data;
					default: begin
					end
				endcase
			end
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						state_q <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					if (mod_rsp.done) begin
						if (take_frame) begin
							marks_q[rem_slot] <= 1'b1;
							cnt_q             <= '0;
							state_q           <= ST_CHECK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CHECK: begin
					state_q <= ST_DSLOT;
				end
				ST_DSLOT: begin
					if (mod_rsp.done) begin
						dslot_q <= rem_slot;
						state_q <= more_deliver ? ST_ADV1 : ST_FINAL;
					end
				end
				ST_ADV1: begin
					if (mod_rsp.done) begin
						ne_nxt_q <= mod_rsp.rem[SEQ_W-1:0];
						state_q  <= ST_ADV2;
					end
				end
				ST_ADV2: begin
					if (mod_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						result_valid_q         <= 1'b1;
						result_q.result_kind   <= KIND_DELIVER;
						result_q.result_number <= ne_q;
						result_q.delivered_tag <= st_rdata;
						result_q.last_result   <= 1'b0;
						marks_q[dslot_q]       <= 1'b0;
						nak_q                  <= 1'b1;
						ne_q                   <= ne_nxt_q;
						wu_q                   <= mod_rsp.rem[SEQ_W-1:0];
						cnt_q                  <= cnt_q + 1'b1;
						state_q                <= ST_CHECK;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						result_valid_q         <= 1'b1;
						result_q.result_number <= ne_q;
						result_q.delivered_tag <= '0;
						result_q.last_result   <= 1'b1;
						if (in_window(ne_q, seq_q, wu_q) && nak_q) begin
							result_q.result_kind <= KIND_NACK;
							nak_q                <= 1'b0;
						end else begin
							result_q.result_kind <= KIND_ACK;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// latched frame header
	always_ff @(posedge clk) begin
		if (accept_in) begin
			seq_q  <= frame.seq_number;
			good_q <= frame.crc_good;
			tag_q  <= frame.frame_tag;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

FILE: src/srrw_mod.sv
// iterative remainder unit, three restoring steps per cycle
`default_nettype none
module srrw_mod
	import srrw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mod_req_t req,
	output mod_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [MOD_W-1:0]     num_q;
	logic [MOD_W-1:0]     den_q;
	logic [MOD_W-1:0]     rem_q;
	logic [MOD_W-1:0]     rem_next;
	logic [MOD_W-1:0]     num_next;

	always_comb begin
		logic [MOD_W:0]   t;
		logic [MOD_W-1:0] r;
		logic [MOD_W-1:0] n;
		r = rem_q;
		n = num_q;
		for (int i = 0; i < MOD_STEPS; i++) begin
			t = {r, n[MOD_W-1]};
			n = {n[MOD_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t = t - {1'b0, den_q};
			end
			r = t[MOD_W-1:0];
		end
		rem_next = r;
		num_next = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= MOD_CNT_W'(MOD_CYCLES);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MOD_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= num_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

FILE: src/srrw_store.sv
// frame tag memory, one write and one registered read port
`default_nettype none
module srrw_store
	import srrw_pkg::*;
(
	input  wire logic       clk,
	input  wire store_req_t req,
	output logic [TAG_W-1:0] rdata
);

	logic [TAG_W-1:0] mem [MAX_WINDOW];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the selective-repeat receive window unit
`timescale 1ns / 1ps
module testbench;
	import srrw_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 frame_valid = 1'b0;
	logic                 frame_ready;
	frame_t               frame = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = CFG_WINDOW_SIZE;
	logic [CFG_W-1:0]     cfg_data = '0;

	// own copy of the receive window
	bit                   held [MAX_WINDOW];
	bit [TAG_W-1:0]       stored_tag [MAX_WINDOW];
	bit [SEQ_W-1:0]       next_seq = '0;
	bit [SEQ_W-1:0]       upper_seq = SEQ_W'(4);
	bit                   nak_armed = 1'b1;
	bit [WS_W-1:0]        win_reg = WS_W'(4);
	bit [CFG_W-1:0]       max_reg = CFG_W'(7);

	frame_t               frames_waiting [$];
	result_t              owed_replies [$];
	result_t              awaited;
	int                   frames_queued = 0;
	int                   error_count = 0;
	int                   send_idle_pct = 0;
	int                   stall_pct = 0;

	selective_repeat_receive_window_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	function automatic int win_eff();
		int w;
		w = int'(win_reg);
		if (w == 0)
			w = 1;
		if (w > MAX_WINDOW)
			w = MAX_WINDOW;
		return w;
	endfunction

	function automatic bit [SEQ_W-1:0] bump(input bit [SEQ_W-1:0] k);
		return SEQ_W'((int'(k) + 1) % (int'(max_reg) + 1));
	endfunction

	function automatic bit between(input bit [SEQ_W-1:0] a, input bit [SEQ_W-1:0] b,
			input bit [SEQ_W-1:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

	task automatic flag_error(input string what);
		if (error_count < 200)
			$display("[%0t] mismatch: %s", $time, what);
		error_count++;
	endtask

	// accept a frame into the window if it is good, new and inside it, then deliver in order and answer
	task automatic take_frame(input frame_t f);
		int w;
		int slot;
		int n;
		result_t r;
		w = win_eff();
		slot = int'(f.seq_number) % w;
		if (!f.crc_good || held[slot] || !between(next_seq, f.seq_number, upper_seq))
			return;
		held[slot] = 1'b1;
		stored_tag[slot] = f.frame_tag;
		n = 0;
		while (held[int'(next_seq) % w] && n < MAX_WINDOW) begin
			slot = int'(next_seq) % w;
			r.result_kind = KIND_DELIVER;
			r.result_number = next_seq;
			r.delivered_tag = stored_tag[slot];
			r.last_result = 1'b0;
			owed_replies.push_back(r);
			n++;
			nak_armed = 1'b1;
			held[slot] = 1'b0;
			next_seq = bump(next_seq);
			upper_seq = bump(upper_seq);
		end
		r.result_number = next_seq;
		r.delivered_tag = '0;
		r.last_result = 1'b1;
		if (!between(next_seq, f.seq_number, upper_seq)) begin
			r.result_kind = KIND_ACK;
		end else if (nak_armed) begin
			nak_armed = 1'b0;
			r.result_kind = KIND_NACK;
		end else begin
			r.result_kind = KIND_ACK;
		end
		owed_replies.push_back(r);
	endtask

	task automatic push_frame(input bit [SEQ_W-1:0] s, input bit g, input bit [TAG_W-1:0] t);
		frame_t f;
		f.seq_number = s;
		f.crc_good = g;
		f.frame_tag = t;
		frames_waiting.push_back(f);
		frames_queued++;
	endtask

	// shuffled run of numbers from the window, with losses, repeats and noise
	task automatic queue_window_batch();
		bit [SEQ_W-1:0] nums [$];
		bit [SEQ_W-1:0] k;
		bit [SEQ_W-1:0] t;
		int i;
		int j;
		int lim;
		lim = win_eff() + 4;
		k = next_seq;
		while (k != upper_seq && nums.size() < lim) begin
			nums.push_back(k);
			k = bump(k);
		end
		if (nums.size() == 0)
			nums.push_back(SEQ_W'($urandom));
		for (i = nums.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = nums[i];
			nums[i] = nums[j];
			nums[j] = t;
		end
		for (i = 0; i < nums.size(); i++) begin
			push_frame(nums[i], $urandom_range(11) != 0, TAG_W'($urandom));
			if ($urandom_range(7) == 0)
				push_frame(nums[i], 1'b1, TAG_W'($urandom));
			if ($urandom_range(5) == 0)
				push_frame(SEQ_W'($urandom), 1'($urandom), TAG_W'($urandom));
		end
	endtask

	task automatic settle(input bit drain_replies);
		do
			@(negedge clk);
		while (frames_waiting.size() != 0 || frame_valid ||
				(drain_replies && owed_replies.size() != 0));
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_WINDOW_SIZE)
			win_reg = val[WS_W-1:0];
		else
			max_reg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
			frame <= '0;
		end else begin
			if (frame_valid && frame_ready)
				take_frame(frame);
			if (!(frame_valid && !frame_ready)) begin
				if (frames_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					frame <= frames_waiting.pop_front();
					frame_valid <= 1'b1;
				end else begin
					frame_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (owed_replies.size() == 0) begin
					flag_error($sformatf("unexpected result %h", result));
				end else begin
					awaited = owed_replies.pop_front();
					if (result.result_kind !== awaited.result_kind)
						flag_error($sformatf("kind got %0d want %0d",
							result.result_kind, awaited.result_kind));
					if (result.result_number !== awaited.result_number)
						flag_error($sformatf("number got %0d want %0d",
							result.result_number, awaited.result_number));
					if (result.delivered_tag !== awaited.delivered_tag)
						flag_error($sformatf("tag got %h want %h",
							result.delivered_tag, awaited.delivered_tag));
					if (result.last_result !== awaited.last_result)
						flag_error($sformatf("last got %b want %b",
							result.last_result, awaited.last_result));
				end
			end
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int p;
		int start;
		int batches;
		logic [CFG_W-1:0] ws;
		logic [CFG_W-1:0] ms;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset window: in order, gaps, repeats, bad crc, outside and oversized numbers
		push_frame(8'd0, 1'b1, 16'hFFFF);
		push_frame(8'd2, 1'b1, 16'h0000);
		push_frame(8'd3, 1'b1, 16'h1234);
		push_frame(8'd2, 1'b1, 16'h5555);
		push_frame(8'd4, 1'b0, 16'hAAAA);
		push_frame(8'd6, 1'b1, 16'h0F0F);
		push_frame(8'd200, 1'b1, 16'hF0F0);
		push_frame(8'd1, 1'b1, 16'hABCD);
		push_frame(8'd7, 1'b1, 16'h8000);
		push_frame(8'd5, 1'b1, 16'h0001);
		push_frame(8'd12, 1'b1, 16'h7FFF);
		push_frame(8'd255, 1'b1, 16'hC3C3);
		push_frame(8'd128, 1'b1, 16'h3C3C);
		push_frame(8'd6, 1'b1, 16'h1111);
		push_frame(8'd7, 1'b1, 16'h2222);
		push_frame(8'd0, 1'b1, 16'h4444);
		push_frame(8'd1, 1'b1, 16'hFFFE);

		for (p = 0; p < 8; p++) begin
			settle(1'b1);
			repeat (40) @(posedge clk);
			case (p)
				0: begin ws = 8'd16; ms = 8'd255; end
				1: begin ws = 8'd31; ms = 8'd255; end
				2: begin ws = 8'd1;  ms = 8'd255; end
				3: begin ws = 8'd0;  ms = 8'd60;  end
				4: begin ws = 8'd8;  ms = 8'd200; end
				5: begin ws = 8'd5;  ms = 8'd3;   end
				6: begin ws = 8'd16; ms = 8'd1;   end
				default: begin ws = 8'd2; ms = 8'd255; end
			endcase
			write_reg(CFG_WINDOW_SIZE, ws);
			write_reg(CFG_MAX_SEQ, ms);
			case ((p + 1) % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 69; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 69; end
				default: begin send_idle_pct = 25; stall_pct = 25; end
			endcase
			start = frames_queued;
			batches = 0;
			while (frames_queued - start < 48 && batches < 300) begin
				// in pass 3, before batch 4, the sender holds off until every reply is in
				if (p == 3 && batches == 4)
					settle(1'b1);
				settle(1'b0);
				queue_window_batch();
				batches++;
			end
		end

		settle(1'b1);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
